// File: rtl/framed_payload_receiver_unit_defines.svh
// assertion macros shared by the framed payload receiver rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef FRAMED_PAYLOAD_RECEIVER_UNIT_DEFINES_SVH
`define FRAMED_PAYLOAD_RECEIVER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define FPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpr assertion failed");
// next-cycle implication, checked outside reset
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpr assertion failed");
`else
`define FPR_ASSERT_NOW(label, clk, rst, ante, cons)
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/fpr_pkg.sv
// types and constants of the framed payload receiver
// no dependencies; imported by every rtl module of the block
package fpr_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'h55;
   localparam logic [7:0] TRL_FIRST  = 8'h55;
   localparam logic [7:0] TRL_SECOND = 8'hAA;
   localparam logic [9:0] FRAME_OVERHEAD = 10'd6;
   localparam logic [8:0] POS_MAX = 9'd511;
   localparam logic [8:0] POS_HDR_FIRST  = 9'd0;
   localparam logic [8:0] POS_HDR_SECOND = 9'd1;
   localparam logic [8:0] POS_LENGTH     = 9'd2;
   localparam logic [9:0] PAYLOAD_START  = 10'd3;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CIPHER_MODE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CIPHER_KEY  = 1'd1;

   localparam logic MODE_XOR    = 1'b0;
   localparam logic MODE_CAESAR = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_FORMAT   = 2'd1,
      STATUS_CHECKSUM = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] plain_byte;
      logic [1:0] frame_status;
      logic [7:0] payload_count;
   } rsp_type;

   typedef struct packed {
      logic       cipher_mode;
      logic [7:0] cipher_key;
   } cfg_type;

endpackage

// File: rtl/fpr_parser.sv
// frame parser: position tracking, checksum, decryption and end-of-frame status
// depends on fpr_pkg
module fpr_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  fpr_pkg::req_type req_data,
   input  fpr_pkg::cfg_type cfg,
   output logic            result_valid,
   output fpr_pkg::rsp_type result_data
);
   import fpr_pkg::*;

   logic [8:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] parity_ff, parity_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] prev_ff, prev_in;
   logic       hdr_bad_ff, hdr_bad_in;

   logic [7:0] b;
   logic [7:0] len_cur;
   logic [9:0] pay_end;
   logic [9:0] total;
   logic [9:0] frame_total;
   logic       in_body;
   logic       is_payload;
   logic       is_check;
   logic       fmt_bad;
   status_type status;

   always_comb begin
      b          = req_data.rx_byte;
      hdr_bad_in = hdr_bad_ff
                   | ((pos_ff == POS_HDR_FIRST) && (b != HDR_FIRST))
                   | ((pos_ff == POS_HDR_SECOND) && (b != HDR_SECOND));
      len_cur    = (pos_ff == POS_LENGTH) ? b : len_ff;
      pay_end    = {2'b00, len_ff} + PAYLOAD_START;
      in_body    = pos_ff > POS_LENGTH;
      is_payload = in_body && ({1'b0, pos_ff} < pay_end);
      is_check   = in_body && ({1'b0, pos_ff} == pay_end);
      parity_in  = is_payload ? (parity_ff ^ b) : parity_ff;
      check_in   = is_check ? b : check_ff;

      total       = {1'b0, pos_ff} + 10'd1;
      frame_total = {2'b00, len_cur} + FRAME_OVERHEAD;
      fmt_bad     = (total < FRAME_OVERHEAD) || hdr_bad_in || (prev_ff != TRL_FIRST)
                    || (b != TRL_SECOND) || (total != frame_total);
      priority if (fmt_bad) begin
         status = STATUS_FORMAT;
      end else if (parity_in != check_in) begin
         status = STATUS_CHECKSUM;
      end else begin
         status = STATUS_GOOD;
      end

      result_data = '0;
      if (req_data.buffer_end) begin
         result_valid               = accept;
         result_data.result_kind    = KIND_STATUS;
         result_data.frame_status   = status;
         result_data.payload_count  = (pos_ff >= POS_LENGTH) ? len_cur : 8'd0;
         pos_in    = '0;
         len_in    = '0;
         prev_in   = '0;
      end else begin
         result_valid            = accept && is_payload;
         result_data.result_kind = KIND_PAYLOAD;
         result_data.plain_byte  = (cfg.cipher_mode == MODE_CAESAR) ?
                                   (b - cfg.cipher_key) : (b ^ cfg.cipher_key);
         pos_in    = (pos_ff < POS_MAX) ? (pos_ff + 9'd1) : POS_MAX;
         len_in    = len_cur;
         prev_in   = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_ff     <= '0;
         parity_ff  <= '0;
         check_ff   <= '0;
         prev_ff    <= '0;
         hdr_bad_ff <= 1'b0;
      end else if (accept) begin
         if (req_data.buffer_end) begin
            // buffer done: start the next one clean
            pos_ff     <= '0;
            len_ff     <= '0;
            parity_ff  <= '0;
            check_ff   <= '0;
            prev_ff    <= '0;
            hdr_bad_ff <= 1'b0;
         end else begin
            pos_ff     <= pos_in;
            len_ff     <= len_in;
            parity_ff  <= parity_in;
            check_ff   <= check_in;
            prev_ff    <= prev_in;
            hdr_bad_ff <= hdr_bad_in;
         end
      end
   end

endmodule

// File: rtl/fpr_out_stage.sv
// result register with a skid entry, so requests flow while a result waits
// depends on fpr_pkg and framed_payload_receiver_unit_defines.svh
`include "framed_payload_receiver_unit_defines.svh"
module fpr_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fpr_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fpr_pkg::rsp_type rsp_data
);
   import fpr_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   always_comb begin
      out_free      = !out_valid_ff || !rsp_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `FPR_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `FPR_ASSERT_NEXT(a_stalled_push_skids, clock, reset, push && out_valid_ff && rsp_stall, skid_valid_ff)
   `FPR_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, out_valid_ff && !skid_valid_ff && (out_data_ff == $past(skid_data_ff)))
   `FPR_ASSERT_NOW(a_no_push_when_full, clock, reset, skid_valid_ff, !push)

endmodule

// File: rtl/framed_payload_receiver_unit.sv
// top level of the framed payload receiver: ports, cipher registers, parser and result stage
// depends on fpr_pkg, fpr_parser and fpr_out_stage
//
// Deframes a byte stream of the form AA 55, length L, L payload bytes, XOR checksum, 55 AA.
// One request (one byte plus an end-of-buffer flag) is taken per clock while req_stall is
// low; each payload byte is decrypted and registered as a result (XOR with the key, or key
// subtracted mod 256 in Caesar mode), and the byte flagged as end of buffer yields one
// status result: good, format error or checksum mismatch, with the declared length. Drop
// the payload bytes of a frame unless its status is good. The parser does all per-byte
// work combinationally; throughput is one request per cycle, limited only by the result
// side: a result register plus one skid entry absorb rsp_stall, and req_stall rises only
// once both hold results. Cipher registers take effect on the next request and should be
// written while no frame is in flight; csr_ready is always high.
module framed_payload_receiver_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  fpr_pkg::req_type                       req_data,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output fpr_pkg::rsp_type                       rsp_data,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fpr_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [7:0]                             csr_wdata
);
   import fpr_pkg::*;

   cfg_type cfg_ff;
   logic    req_accept;
   logic    result_valid;
   rsp_type result_data;
   logic    out_full;

   // register writes never wait
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CIPHER_MODE: begin
               cfg_ff.cipher_mode <= csr_wdata[0];
            end
            CSR_CIPHER_KEY: begin
               cfg_ff.cipher_key <= csr_wdata;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // stall only when the result side is holding two results
   assign req_stall  = out_full;
   assign req_accept = req_valid && !req_stall;

   // per-byte parsing, checksum and decryption
   fpr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req_data     (req_data),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result_data  (result_data)
   );

   // result register and skid entry
   fpr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result_data),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
